FILE: rtl/core/rtp_pkg.sv
`default_nettype none
package rtp_pkg;
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned ROM_STEPS = 600;
  localparam int unsigned ROM_SCALE = 10000;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Whole-degree arctangent: the degree value of each table entry after the
  // divide by ROM_SCALE. Boundaries are the first index at which each degree
  // is reached in the fixed-point table.
  function automatic logic [5:0] atan_deg(input logic [9:0] idx);
    logic [5:0] d;
    d = 6'd0;
    if (idx >= 10'd11)  d = 6'd1;
    if (idx >= 10'd21)  d = 6'd2;
    if (idx >= 10'd32)  d = 6'd3;
    if (idx >= 10'd42)  d = 6'd4;
    if (idx >= 10'd53)  d = 6'd5;
    if (idx >= 10'd64)  d = 6'd6;
    if (idx >= 10'd74)  d = 6'd7;
    if (idx >= 10'd85)  d = 6'd8;
    if (idx >= 10'd96)  d = 6'd9;
    if (idx >= 10'd106) d = 6'd10;
    if (idx >= 10'd117) d = 6'd11;
    if (idx >= 10'd128) d = 6'd12;
    if (idx >= 10'd139) d = 6'd13;
    if (idx >= 10'd150) d = 6'd14;
    if (idx >= 10'd161) d = 6'd15;
    if (idx >= 10'd173) d = 6'd16;
    if (idx >= 10'd184) d = 6'd17;
    if (idx >= 10'd195) d = 6'd18;
    if (idx >= 10'd207) d = 6'd19;
    if (idx >= 10'd219) d = 6'd20;
    if (idx >= 10'd231) d = 6'd21;
    if (idx >= 10'd243) d = 6'd22;
    if (idx >= 10'd255) d = 6'd23;
    if (idx >= 10'd268) d = 6'd24;
    if (idx >= 10'd280) d = 6'd25;
    if (idx >= 10'd293) d = 6'd26;
    if (idx >= 10'd306) d = 6'd27;
    if (idx >= 10'd320) d = 6'd28;
    if (idx >= 10'd333) d = 6'd29;
    if (idx >= 10'd347) d = 6'd30;
    if (idx >= 10'd361) d = 6'd31;
    if (idx >= 10'd375) d = 6'd32;
    if (idx >= 10'd390) d = 6'd33;
    if (idx >= 10'd405) d = 6'd34;
    if (idx >= 10'd421) d = 6'd35;
    if (idx >= 10'd436) d = 6'd36;
    if (idx >= 10'd453) d = 6'd37;
    if (idx >= 10'd469) d = 6'd38;
    if (idx >= 10'd486) d = 6'd39;
    if (idx >= 10'd504) d = 6'd40;
    if (idx >= 10'd522) d = 6'd41;
    if (idx >= 10'd541) d = 6'd42;
    if (idx >= 10'd560) d = 6'd43;
    if (idx >= 10'd580) d = 6'd44;
    if (idx >= 10'd600) d = 6'd45;
    return d;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/rect_to_polar_integer_core.sv
`default_nettype none
// Rectangular to polar converter. Each transaction on the input channel
// carries a signed vector (in_comp_a as x, in_comp_b as y); the result
// transaction carries the rounded integer magnitude and the direction in
// whole degrees, -180 to 180, from a 1/600-step arctangent table unfolded by
// octant. A zero vector gives magnitude 0 and direction 0. Only the low
// COORD_BITS bits of each component are used. The core handles one
// transaction at a time: squaring runs on one shared multiplier, the root
// takes one result bit per cycle (restoring digit loop), and the ratio
// y*600/x is then found by restoring division. The result is held until it
// is taken and in_ready returns in the following cycle. in_ready is high
// only while the core is idle.
module rect_to_polar_integer_core #(
  parameter int unsigned COORD_BITS = rtp_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_comp_a,
  input  wire logic signed [31:0] in_comp_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_magnitude,
  output logic signed [8:0]       out_direction_deg
);
  import rtp_pkg::*;

  localparam int unsigned DIV_STEPS = 11; // quotient of y*600/x fits 10 bits

  state_t       state_r, state_nxt;
  logic [5:0]   cnt_r;
  logic [31:0]  ax_r, ay_r;          // absolute values, x >= y after swap
  logic         xneg_r, yneg_r, swap_r;
  logic [63:0]  rad_r;               // a^2 + b^2, then remainder
  logic [32:0]  root_r;
  logic [63:0]  prod_r;
  logic [41:0]  num_r;               // y*600 shifted left during division
  logic [32:0]  rem_r;
  logic [10:0]  quo_r;

  logic [31:0]  abs_a, abs_b;
  logic         neg_a, neg_b;
  logic [COORD_BITS-1:0] fa, fb, na, nb;
  logic [31:0]  mul_op;
  logic [63:0]  mul_res;

  // Sign split from bit COORD_BITS-1; the most negative value maps to 2^(N-1).
  always_comb begin
    fa = in_comp_a[COORD_BITS-1:0];
    fb = in_comp_b[COORD_BITS-1:0];
    na = ~fa + 1'b1;
    nb = ~fb + 1'b1;
    neg_a = fa[COORD_BITS-1];
    neg_b = fb[COORD_BITS-1];
    abs_a = 32'(neg_a ? na : fa);
    abs_b = 32'(neg_b ? nb : fb);
  end

  // One shared squarer: first x, then y.
  assign mul_op  = (cnt_r == 6'd0) ? ax_r : ay_r;
  assign mul_res = {32'd0, mul_op} * {32'd0, mul_op};

  // Root step: trial bit pair at position cnt.
  logic [65:0] trial;
  logic [65:0] rem_sh;
  logic [32:0] div_trial;
  always_comb begin
    rem_sh = {2'b0, rad_r} >> {cnt_r[4:0], 1'b0};
    trial  = {31'd0, root_r, 2'b01};
    div_trial = {rem_r[31:0], num_r[41]};
  end

  logic [5:0] deg;
  logic [9:0] idx;
  logic signed [9:0] r0, r1, r2, r3;
  always_comb begin
    idx = (quo_r > 11'(ROM_STEPS)) ? 10'(ROM_STEPS) : quo_r[9:0];
    deg = atan_deg(idx);
    r0  = 10'(deg);
    r1  = swap_r ? 10'sd90 - r0 : r0;
    r2  = xneg_r ? 10'sd180 - r1 : r1;
    r3  = yneg_r ? -r2 : r2;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SQ;
      ST_SQ:   if (cnt_r == 6'd1) state_nxt = ST_ROOT;
      ST_ROOT: if (cnt_r == 6'd0) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: cnt_r <= 6'd0;
        ST_SQ:   cnt_r <= (cnt_r == 6'd1) ? 6'd31 : cnt_r + 6'd1;
        ST_ROOT: cnt_r <= (cnt_r == 6'd0) ? 6'd0 : cnt_r - 6'd1;
        ST_DIV:  cnt_r <= cnt_r + 6'd1;
        ST_DONE: cnt_r <= 6'd0;
        default: cnt_r <= 6'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          swap_r <= abs_a < abs_b;
          ax_r   <= (abs_a < abs_b) ? abs_b : abs_a;
          ay_r   <= (abs_a < abs_b) ? abs_a : abs_b;
          xneg_r <= neg_a;
          yneg_r <= neg_b;
          rad_r  <= 64'd0;
        end
      end
      ST_SQ: begin
        rad_r  <= rad_r + mul_res;
        root_r <= 33'd0;
        if (cnt_r == 6'd1) prod_r <= {32'd0, ay_r} * 64'(ROM_STEPS);
      end
      ST_ROOT: begin
        // Classic bit-pair root: compare (root<<2 | 1) against remainder top.
        if (rem_sh >= trial) begin
          rad_r  <= rad_r - 64'(trial << {cnt_r[4:0], 1'b0});
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          root_r <= {root_r[31:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          num_r <= prod_r[41:0];
          rem_r <= 33'd0;
          quo_r <= 11'd0;
        end
      end
      ST_DIV: begin
        // Restoring division of y*600 by x, top bits only.
        if (cnt_r == 6'd0) begin
          // Quotient < 1024; skip the leading 31 bits: they are below x.
          rem_r <= 33'(num_r[41:10] >= ax_r ? num_r[41:10] - ax_r : num_r[41:10]);
          quo_r <= {10'd0, num_r[41:10] >= ax_r};
          num_r <= {num_r[9:0], 32'd0};
        end else begin
          if (div_trial >= {1'b0, ax_r}) begin
            rem_r <= div_trial - {1'b0, ax_r};
            quo_r <= {quo_r[9:0], 1'b1};
          end else begin
            rem_r <= div_trial;
            quo_r <= {quo_r[9:0], 1'b0};
          end
          num_r <= {num_r[40:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_magnitude = (rad_r > 64'(root_r)) ? root_r[31:0] + 32'd1 : root_r[31:0];
  assign out_direction_deg = (ax_r == 32'd0) ? 9'sd0 : r3[8:0];
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard for the polar converter. It computes the expected magnitude and
// direction of each accepted vector and compares result transactions in order.
class polar_scoreboard;
  logic [31:0] mag_q[$];
  logic [8:0]  dir_q[$];
  int          errors;

  // Whole-degree arctangent for a ratio index of 0..600. The degree steps at
  // the first index whose table entry reaches the next multiple of 10000.
  static function int unsigned deg_at(int unsigned idx);
    int unsigned edges[45] = '{11, 21, 32, 42, 53, 64, 74, 85, 96, 106, 117, 128,
      139, 150, 161, 173, 184, 195, 207, 219, 231, 243, 255, 268, 280, 293, 306,
      320, 333, 347, 361, 375, 390, 405, 421, 436, 453, 469, 486, 504, 522, 541,
      560, 580, 600};
    int unsigned d;
    d = 0;
    foreach (edges[i]) if (idx >= edges[i]) d = i + 1;
    return d;
  endfunction

  static function logic [31:0] rounded_root(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (x > res) res = res + 1;
    return res[31:0];
  endfunction

  function void note_vector(logic [31:0] a, logic [31:0] b);
    logic [63:0] ax, ay, t, idx;
    logic        xneg, yneg, swapped;
    int          r;
    xneg = a[31];
    yneg = b[31];
    ax = xneg ? {32'd0, -a} : {32'd0, a};
    ay = yneg ? {32'd0, -b} : {32'd0, b};
    mag_q.push_back(rounded_root(ax * ax + ay * ay));
    swapped = 0;
    if (ax < ay) begin
      t = ax; ax = ay; ay = t; swapped = 1;
    end
    if (ax == 0) begin
      r = 0;
    end else begin
      idx = (ay * 600) / ax;
      if (idx > 600) idx = 600;
      r = deg_at(idx);
      if (swapped) r = 90 - r;
      if (xneg) r = 180 - r;
      if (yneg) r = -r;
    end
    dir_q.push_back(r[8:0]);
  endfunction

  function void check_result(logic [31:0] mag, logic [8:0] dir);
    logic [31:0] em;
    logic [8:0]  ed;
    if (mag_q.size() == 0) begin
      $error("result transaction with no vector outstanding");
      errors++;
      return;
    end
    em = mag_q.pop_front();
    ed = dir_q.pop_front();
    if (mag !== em) begin
      $error("magnitude: expected %0d, got %0d", em, mag);
      errors++;
    end
    if (dir !== ed) begin
      $error("direction_deg: expected %0d, got %0d", $signed(ed), $signed(dir));
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int NUM_RANDOM = 1830;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [31:0] in_comp_a = 0;
  logic signed [31:0] in_comp_b = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [31:0]        out_magnitude;
  logic signed [8:0]  out_direction_deg;

  polar_scoreboard sb = new();
  bit sending_done = 0;
  // Asks the receiver for one long hold-off; the receiver clears it when done.
  bit hold_off = 0;

  // Axes, diagonals in every quadrant, full scale, the most negative
  // value, ratios near table edges and the zero vector.
  logic [31:0] dir_a[25] = '{0, 5, -5, 0, 0, 7, -7, 7, -7, 32'h7FFF_FFFF,
    32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 0,
    32'h8000_0000, 32'hFFFF_FFFF, 1, 600, 1000, 3, 32'h7FFF_FFFF, 1, 2, 0};
  logic [31:0] dir_b[25] = '{0, 0, 0, 5, -5, 7, 7, -7, -7, 32'h7FFF_FFFF,
    32'h8000_0001, 32'h8000_0001, 32'h7FFF_FFFF, 0, 32'h8000_0000,
    32'h8000_0000, 32'hFFFF_FFFF, 600, 1, 999, 4, 1, 32'h7FFF_FFFF, 1, 1};

  always #6 clk = ~clk;

  rect_to_polar_integer_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_comp_a(in_comp_a), .in_comp_b(in_comp_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_magnitude(out_magnitude), .out_direction_deg(out_direction_deg)
  );

  // Mostly short gaps, occasionally a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  // Offer one vector and wait until the transaction completes. The sampled
  // handshake is taken just after the edge, so the scoreboard is updated
  // from stable values. Valid drops only when a gap follows.
  task automatic send_vector(logic [31:0] a, logic [31:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_comp_a <= a;
    in_comp_b <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_vector(a, b);
  endtask

  // Random component: full range, small values, or near full scale.
  function automatic logic [31:0] rand_comp();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 16);
      1: v = 32'h7FFF_FFFF - $urandom_range(0, 16);
      2: v = $urandom_range(0, 65535);
      default: v = $urandom();
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  initial begin
    logic [31:0] m;
    int          k;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    for (int i = 0; i < 25; i++) send_vector(dir_a[i], dir_b[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) hold_off = 1;
      k = $urandom_range(0, 9);
      if (k == 0) begin
        // Equal magnitudes with random signs.
        m = $urandom() & 32'h7FFF_FFFF;
        send_vector($urandom_range(0, 1) ? m : -m, $urandom_range(0, 1) ? m : -m);
      end else if (k == 1) begin
        send_vector(rand_comp(), 0);
      end else if (k == 2) begin
        send_vector(0, rand_comp());
      end else begin
        send_vector(rand_comp(), rand_comp());
      end
    end
    in_valid <= 0;
    sending_done = 1;
  end

  // Receiver: random stalls, plus one long hold-off that fills the core
  // while the sender keeps offering.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_magnitude, out_direction_deg);
  end

  initial begin
    wait (sending_done);
    wait (sb.mag_q.size() == 0);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.mag_q.size() == 0) begin
      $display("rect_to_polar_integer_core verification clean");
    end else begin
      $display("rect_to_polar_integer_core verification failed");
    end
    $finish;
  end

  // Worst case covers 1855 transactions, each with the core's full latency and the longest gaps on both sides.
  initial begin
    #20_000_000;
    $display("rect_to_polar_integer_core verification failed");
    $finish;
  end
endmodule

`default_nettype wire

FILE: sim.f
rtl/core/rtp_pkg.sv
rtl/core/rect_to_polar_integer_core.sv
tb/tb_top.sv
